### sv/max_min_task_scheduler_top_assert.svh
// assertion macros used by the scheduler control module
// both expect signals named clk and rst_n in the enclosing module
`ifndef MAX_MIN_TASK_SCHEDULER_TOP_ASSERT_SVH
`define MAX_MIN_TASK_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define MMTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MMTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mmts_pkg.sv
package mmts_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_MACHINES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TASKS    = 1'b1;

  localparam int NM_REG_W = 4;
  localparam int NT_REG_W = 5;
  localparam logic [NM_REG_W-1:0] NM_RESET = 4'd8;
  localparam logic [NT_REG_W-1:0] NT_RESET = 5'd16;

  // a run returns at most this many results
  localparam int RESULT_LIMIT = 16;

  // field widths
  localparam int MACH_IDX_W = 3;
  localparam int TASK_IDX_W = 4;
  localparam int TIME_W     = 16;
  // completion times stay at or below 16 * 65535
  localparam int CT_W       = 20;

  localparam int IN_FIELDS_W  = MACH_IDX_W + TASK_IDX_W + TIME_W;
  localparam int OUT_FIELDS_W = TASK_IDX_W + MACH_IDX_W + TIME_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic load;        // input beat accepted
    logic clear_run;   // clear ready times and done marks
    logic clear_best;  // start a new round
    logic issue;       // matrix read for one machine/task pair
    logic issue_first; // first machine of a task
    logic issue_last;  // last machine of a task
    logic emit;        // commit the round's pick and register the result
    logic emit_final;  // last result of the run
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;      // reads still in flight
    logic out_free;  // result register can take a beat
  } dp_sts_t;

endpackage

### sv/mmts_ctrl.sv
`include "max_min_task_scheduler_top_assert.svh"

module mmts_ctrl #(
  parameter int MAX_MACHINES = 8,
  parameter int MAX_TASKS    = 16,
  parameter int MW           = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mmts_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [mmts_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  input  logic                                in_tlast,
  output logic                                in_tready,
  input  mmts_pkg::dp_sts_t                   sts,
  output mmts_pkg::ctrl_cmd_t                 cmd,
  output logic [MW-1:0]                       issue_m,
  output logic [mmts_pkg::TASK_IDX_W-1:0]     issue_t
);

  localparam int TASK_CAP = (MAX_TASKS < mmts_pkg::RESULT_LIMIT) ?
                            MAX_TASKS : mmts_pkg::RESULT_LIMIT;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [mmts_pkg::NM_REG_W-1:0]   num_machines_r;
  logic [mmts_pkg::NT_REG_W-1:0]   num_tasks_r;
  logic [MW-1:0]                   m_cnt_r, m_cnt_nxt;
  logic [mmts_pkg::TASK_IDX_W-1:0] t_cnt_r, t_cnt_nxt;
  logic [mmts_pkg::TASK_IDX_W-1:0] round_r, round_nxt;

  logic [mmts_pkg::NM_REG_W-1:0]   nm_act;
  logic [mmts_pkg::NT_REG_W-1:0]   nt_act;
  logic [mmts_pkg::NM_REG_W-1:0]   nm_last;
  logic [mmts_pkg::TASK_IDX_W-1:0] nt_last;
  logic                            accept;
  logic                            go;
  logic                            m_at_last;
  logic                            t_at_last;
  logic                            round_final;
  logic                            emit_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_machines_r <= mmts_pkg::NM_RESET;
      num_tasks_r    <= mmts_pkg::NT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        mmts_pkg::REG_NUM_MACHINES: num_machines_r <= cfg_wdata[mmts_pkg::NM_REG_W-1:0];
        mmts_pkg::REG_NUM_TASKS:    num_tasks_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // saturate the register values to what the storage holds
  assign nm_act = (32'(num_machines_r) > MAX_MACHINES) ?
                  mmts_pkg::NM_REG_W'(MAX_MACHINES) : num_machines_r;
  assign nt_act = (32'(num_tasks_r) > TASK_CAP) ?
                  mmts_pkg::NT_REG_W'(TASK_CAP) : num_tasks_r;
  assign nm_last = nm_act - 4'd1;
  assign nt_last = mmts_pkg::TASK_IDX_W'(nt_act - 5'd1);

  assign in_tready   = (state_r == ST_LOAD);
  assign accept      = in_tvalid && in_tready;
  assign go          = accept && in_tlast && (nm_act != '0) && (nt_act != '0);
  assign m_at_last   = (m_cnt_r == MW'(nm_last));
  assign t_at_last   = (t_cnt_r == nt_last);
  assign round_final = (round_r == nt_last);
  assign emit_now    = (state_r == ST_EMIT) && sts.out_free;

  always_comb begin
    cmd             = '0;
    cmd.load        = accept;
    cmd.clear_run   = accept && in_tlast;
    cmd.clear_best  = go || emit_now;
    cmd.issue       = (state_r == ST_SCAN);
    cmd.issue_first = (m_cnt_r == '0);
    cmd.issue_last  = m_at_last;
    cmd.emit        = emit_now;
    cmd.emit_final  = round_final;
  end

  assign issue_m = m_cnt_r;
  assign issue_t = t_cnt_r;

  always_comb begin
    state_nxt = state_r;
    m_cnt_nxt = m_cnt_r;
    t_cnt_nxt = t_cnt_r;
    round_nxt = round_r;
    case (state_r)
      ST_LOAD: begin
        if (go) begin
          state_nxt = ST_SCAN;
          m_cnt_nxt = '0;
          t_cnt_nxt = '0;
          round_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (m_at_last) begin
          m_cnt_nxt = '0;
          t_cnt_nxt = t_cnt_r + 4'd1;
          if (t_at_last) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          m_cnt_nxt = m_cnt_r + MW'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_now) begin
          if (round_final) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_SCAN;
            round_nxt = round_r + 4'd1;
            m_cnt_nxt = '0;
            t_cnt_nxt = '0;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      m_cnt_r <= '0;
      t_cnt_r <= '0;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      m_cnt_r <= m_cnt_nxt;
      t_cnt_r <= t_cnt_nxt;
      round_r <= round_nxt;
    end
  end

  `MMTS_ASSERT_IMP(a_emit_needs_room, cmd.emit, sts.out_free, "result emitted into a full register")
  `MMTS_ASSERT_IMP(a_scan_in_range, state_r == ST_SCAN, (m_cnt_r <= MW'(nm_last)) && (t_cnt_r <= nt_last), "scan counter past the active range")
  `MMTS_ASSERT_IMP(a_drain_done, emit_now, !sts.busy, "result emitted with reads in flight")
  `MMTS_ASSERT_NXT(a_final_to_load, cmd.emit && cmd.emit_final, state_r == ST_LOAD, "run did not end after its final result")

endmodule

### sv/mmts_dpath.sv
module mmts_dpath #(
  parameter int MAX_MACHINES = 8,
  parameter int MAX_TASKS    = 16,
  parameter int MW           = 3,
  parameter int TW           = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mmts_pkg::ctrl_cmd_t                 cmd,
  input  logic [MW-1:0]                       issue_m,
  input  logic [mmts_pkg::TASK_IDX_W-1:0]     issue_t,
  input  logic [mmts_pkg::MACH_IDX_W-1:0]     in_machine_index,
  input  logic [mmts_pkg::TASK_IDX_W-1:0]     in_task_index,
  input  logic [mmts_pkg::TIME_W-1:0]         in_run_time,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic                                out_final_assignment,
  output logic [mmts_pkg::TASK_IDX_W-1:0]     out_chosen_task,
  output logic [mmts_pkg::MACH_IDX_W-1:0]     out_chosen_machine,
  output logic [mmts_pkg::TIME_W-1:0]         out_task_time,
  output mmts_pkg::dp_sts_t                   sts
);

  localparam int AW     = MW + TW;
  localparam int DEPTH  = MAX_MACHINES * (2 ** TW);
  localparam int DONE_N = (MAX_TASKS < mmts_pkg::RESULT_LIMIT) ?
                          MAX_TASKS : mmts_pkg::RESULT_LIMIT;
  localparam int DW     = (DONE_N > 1) ? $clog2(DONE_N) : 1;

  logic [mmts_pkg::TIME_W-1:0] mem [DEPTH];
  logic [mmts_pkg::TIME_W-1:0] rd_data_r;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;

  logic [mmts_pkg::CT_W-1:0] ready_r [MAX_MACHINES];
  logic [DONE_N-1:0]         done_r;

  // read stage
  logic                            p1_v_r, p1_first_r, p1_last_r, p1_done_r;
  logic [MW-1:0]                   p1_m_r;
  logic [mmts_pkg::TASK_IDX_W-1:0] p1_t_r;
  // completion time stage
  logic                            p2_v_r, p2_first_r, p2_last_r, p2_done_r;
  logic [MW-1:0]                   p2_m_r;
  logic [mmts_pkg::TASK_IDX_W-1:0] p2_t_r;
  logic [mmts_pkg::CT_W-1:0]       p2_ct_r;
  logic [mmts_pkg::TIME_W-1:0]     p2_time_r;
  // per-task least completion time
  logic [mmts_pkg::CT_W-1:0]       least_ct_r, cur_ct;
  logic [MW-1:0]                   least_m_r, cur_m;
  logic [mmts_pkg::TIME_W-1:0]     least_time_r, cur_time;
  logic                            take;
  // end of task
  logic                            te_v_r;
  logic [mmts_pkg::CT_W-1:0]       te_ct_r;
  logic [MW-1:0]                   te_m_r;
  logic [mmts_pkg::TASK_IDX_W-1:0] te_t_r;
  logic [mmts_pkg::TIME_W-1:0]     te_time_r;
  // round winner
  logic                            have_r;
  logic [mmts_pkg::CT_W-1:0]       best_ct_r;
  logic [MW-1:0]                   best_m_r;
  logic [mmts_pkg::TASK_IDX_W-1:0] best_t_r;
  logic [mmts_pkg::TIME_W-1:0]     best_time_r;

  logic                            out_valid_r;
  logic                            out_final_r;
  logic [mmts_pkg::TASK_IDX_W-1:0] out_task_r;
  logic [mmts_pkg::MACH_IDX_W-1:0] out_mach_r;
  logic [mmts_pkg::TIME_W-1:0]     out_time_r;

  // entries outside the stored matrix are dropped
  assign wr_en   = cmd.load && (32'(in_machine_index) < MAX_MACHINES) &&
                   (32'(in_task_index) < MAX_TASKS);
  assign wr_addr = {MW'(in_machine_index), TW'(in_task_index)};
  assign rd_addr = {issue_m, TW'(issue_t)};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_run_time;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    p1_m_r     <= issue_m;
    p1_t_r     <= issue_t;
    p1_first_r <= cmd.issue_first;
    p1_last_r  <= cmd.issue_last;
    p1_done_r  <= done_r[DW'(issue_t)];
    p2_m_r     <= p1_m_r;
    p2_t_r     <= p1_t_r;
    p2_first_r <= p1_first_r;
    p2_last_r  <= p1_last_r;
    p2_done_r  <= p1_done_r;
    p2_time_r  <= rd_data_r;
    p2_ct_r    <= ready_r[p1_m_r] + mmts_pkg::CT_W'(rd_data_r);
  end

  // strict compare keeps the lowest machine on ties
  assign take     = p2_first_r || (p2_ct_r < least_ct_r);
  assign cur_ct   = take ? p2_ct_r   : least_ct_r;
  assign cur_m    = take ? p2_m_r    : least_m_r;
  assign cur_time = take ? p2_time_r : least_time_r;

  always_ff @(posedge clk) begin
    if (p2_v_r) begin
      least_ct_r   <= cur_ct;
      least_m_r    <= cur_m;
      least_time_r <= cur_time;
    end
    te_ct_r   <= cur_ct;
    te_m_r    <= cur_m;
    te_t_r    <= p2_t_r;
    te_time_r <= cur_time;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      te_v_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.issue;
      p2_v_r <= p1_v_r;
      te_v_r <= p2_v_r && p2_last_r && !p2_done_r;
    end
  end

  // strict compare keeps the lowest task on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (cmd.clear_best) begin
      have_r <= 1'b0;
    end else if (te_v_r && (!have_r || (te_ct_r > best_ct_r))) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (te_v_r && (!have_r || (te_ct_r > best_ct_r))) begin
      best_ct_r   <= te_ct_r;
      best_m_r    <= te_m_r;
      best_t_r    <= te_t_r;
      best_time_r <= te_time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_run) begin
      for (int i = 0; i < MAX_MACHINES; i++) begin
        ready_r[i] <= '0;
      end
      done_r <= '0;
    end else if (cmd.emit) begin
      ready_r[best_m_r]       <= best_ct_r;
      done_r[DW'(best_t_r)]   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_task_r  <= best_t_r;
      out_mach_r  <= mmts_pkg::MACH_IDX_W'(best_m_r);
      out_time_r  <= best_time_r;
      out_final_r <= cmd.emit_final;
    end
  end

  assign out_tvalid           = out_valid_r;
  assign out_final_assignment = out_final_r;
  assign out_chosen_task      = out_task_r;
  assign out_chosen_machine   = out_mach_r;
  assign out_task_time        = out_time_r;

  assign sts.busy     = p1_v_r || p2_v_r || te_v_r;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

### sv/max_min_task_scheduler_top.sv
// channel   | dir | tdata (low bit up)                              | tlast
// ----------+-----+-------------------------------------------------+-----------------
// in_       | in  | machine_index[2:0] task_index[6:3] run_time[22:7] | last_entry
// out_      | out | chosen_task[3:0] chosen_machine[6:4] task_time[22:7] | final_assignment
// cfg_      | in  | index 0 num_machines, index 1 num_tasks          | -
//
// matrix beats load one per cycle; a beat with tlast starts a run when both counts are nonzero, and
// in_tready then stays low until the run's final result sits in the output register.
// each round reads every machine/task pair on the single matrix read port, then drains the
// read, completion time and end of task registers and commits its pick; one round per task.
// a stalled out_ side holds the next round's commit; scanning resumes once the beat is taken.
// rst_n is synchronous; after it the registers read 8 machines and 16 tasks and the matrix
// holds nothing until written.
module max_min_task_scheduler_top #(
  parameter int MAX_MACHINES = 8,
  parameter int MAX_TASKS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mmts_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [mmts_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // machine_index[2:0], task_index[6:3], run_time[22:7], zero pad
  input  logic [mmts_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // chosen_task[3:0], chosen_machine[6:4], task_time[22:7], zero pad
  output logic [mmts_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast
);

  localparam int MW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  mmts_pkg::ctrl_cmd_t             cmd;
  mmts_pkg::dp_sts_t               sts;
  logic [MW-1:0]                   issue_m;
  logic [mmts_pkg::TASK_IDX_W-1:0] issue_t;
  logic [mmts_pkg::TASK_IDX_W-1:0] chosen_task;
  logic [mmts_pkg::MACH_IDX_W-1:0] chosen_machine;
  logic [mmts_pkg::TIME_W-1:0]     task_time;

  mmts_ctrl #(
    .MAX_MACHINES (MAX_MACHINES),
    .MAX_TASKS    (MAX_TASKS),
    .MW           (MW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .issue_m   (issue_m),
    .issue_t   (issue_t)
  );

  mmts_dpath #(
    .MAX_MACHINES (MAX_MACHINES),
    .MAX_TASKS    (MAX_TASKS),
    .MW           (MW),
    .TW           (TW)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .issue_m              (issue_m),
    .issue_t              (issue_t),
    .in_machine_index     (in_tdata[2:0]),
    .in_task_index        (in_tdata[6:3]),
    .in_run_time          (in_tdata[22:7]),
    .out_tready           (out_tready),
    .out_tvalid           (out_tvalid),
    .out_final_assignment (out_tlast),
    .out_chosen_task      (chosen_task),
    .out_chosen_machine   (chosen_machine),
    .out_task_time        (task_time),
    .sts                  (sts)
  );

  assign out_tdata = {{(mmts_pkg::OUT_TDATA_W - mmts_pkg::OUT_FIELDS_W){1'b0}},
                      task_time, chosen_machine, chosen_task};

endmodule
